>>> hw/rtl/scf_pkg.sv
// Shared types and constants of the cross-kernel sharpening filter.
package scf_pkg;

  localparam int unsigned WIDTH_REG_BITS  = 11;
  localparam int unsigned HEIGHT_REG_BITS = 13;
  localparam int unsigned IN_CH_BITS      = 8;
  localparam int unsigned OUT_CH_BITS     = 8;
  localparam int unsigned APB_ADDR_BITS   = 3;
  localparam int unsigned APB_DATA_BITS   = 32;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd1024;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;

  typedef struct packed {
    logic use_up;
    logic use_dn;
    logic use_lf;
    logic use_rt;
    logic fwd_c;
    logic fwd_dn;
    logic fwd_rt;
    logic frame_end;
  } scf_sel_t;

endpackage

>>> hw/rtl/sharpen_cross_kernel_filter.sv
// Top level of the 3x3 cross-kernel sharpening filter for an RGB pixel stream.
// Throughput is one transaction per cycle while the input is not stalled, pixel or drain tick alike.
// After the transaction that completes its neighborhood, the pixel memories are read synchronously
// into registers and the arithmetic result is registered at the output; a stalled output can hold it in between.
// In a steady stream that transaction brings the pixel one row below the center pixel.
// Reset clears the control state and sets both size registers to 1024; memories keep old data.
module sharpen_cross_kernel_filter
  import scf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic [IN_CH_BITS-1:0]    red_in_i,
  input  logic [IN_CH_BITS-1:0]    green_in_i,
  input  logic [IN_CH_BITS-1:0]    blue_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [OUT_CH_BITS-1:0]   red_out_o,
  output logic [OUT_CH_BITS-1:0]   green_out_o,
  output logic [OUT_CH_BITS-1:0]   blue_out_o,
  output logic                     frame_end_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int unsigned RING = 2 * MAX_WIDTH + 2;
  localparam int unsigned AW   = $clog2(RING);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW   = $clog2(MAX_WIDTH + 2);
  localparam int unsigned HW   = HEIGHT_REG_BITS;
  localparam int unsigned CB   = CHANNEL_BITS;
  localparam int unsigned PXW  = 3 * CHANNEL_BITS;
  localparam int unsigned SW   = CHANNEL_BITS + 4;
  localparam logic signed [SW-1:0] CH_MAX_S = $signed({4'b0000, {CHANNEL_BITS{1'b1}}});

  function automatic logic [CB-1:0] take_ch(input logic [IN_CH_BITS-1:0] x);
    logic [CB+IN_CH_BITS-1:0] xe;
    xe = {{CB{1'b0}}, x};
    return xe[CB-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] wr, input logic [AW-1:0] back);
    logic [AW:0] d;
    d = {1'b0, wr} - {1'b0, back};
    if (d[AW]) begin
      d = d + (AW+1)'(RING);
    end
    return d[AW-1:0];
  endfunction

  function automatic logic [OUT_CH_BITS-1:0] sharpen(
    input logic [CB-1:0] c,
    input logic [CB-1:0] u,
    input logic [CB-1:0] d,
    input logic [CB-1:0] l,
    input logic [CB-1:0] r
  );
    logic signed [SW-1:0] cs, us, ds, ls, rs, acc;
    logic [CB-1:0] cl;
    logic [CB+OUT_CH_BITS-1:0] ext;
    cs  = $signed({4'b0000, c});
    us  = $signed({4'b0000, u});
    ds  = $signed({4'b0000, d});
    ls  = $signed({4'b0000, l});
    rs  = $signed({4'b0000, r});
    acc = (cs <<< 2) + cs - us - ds - ls - rs;
    if (acc[SW-1]) begin
      cl = '0;
    end else if (acc > CH_MAX_S) begin
      cl = '1;
    end else begin
      cl = acc[CB-1:0];
    end
    ext = {{OUT_CH_BITS{1'b0}}, cl};
    return ext[OUT_CH_BITS-1:0];
  endfunction

  logic [WIDTH_REG_BITS-1:0]  width_q, width_d;
  logic [HEIGHT_REG_BITS-1:0] height_q, height_d;
  logic [AW-1:0]              wr_q, wr_d;
  logic [PW-1:0]              pending_q, pending_d;
  logic [WW-1:0]              out_col_q, out_col_d;
  logic [HW-1:0]              out_row_q, out_row_d;
  logic                       s1_valid_q, s1_valid_d;
  scf_sel_t                   s1_sel_q, sel_d;
  logic [PXW-1:0]             s1_wdata_q;
  logic                       out_valid_q, out_valid_d;
  logic [OUT_CH_BITS-1:0]     red_q, green_q, blue_q;
  logic                       frame_end_q;
  logic [PXW-1:0]             prev_c_q;

  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic           cfg_wr, acc, pix, emit, adv1, last_row, last_col;
  logic [PW-1:0]  b;
  logic [AW-1:0]  back_c, back_up, back_dn, back_rt;
  logic [AW-1:0]  addr_c, addr_up, addr_dn, addr_rt;
  logic [PXW-1:0] wdata;

  logic [PXW-1:0] mem_a [RING];
  logic [PXW-1:0] mem_b [RING];
  logic [PXW-1:0] rd_c_q, rd_up_q, rd_dn_q, rd_rt_q;
  logic [PXW-1:0] cpx, upx, dnx, lfx, rtx;
  logic [OUT_CH_BITS-1:0] res [3];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[APB_ADDR_BITS-1])
      REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(height_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    eff_h = (height_q == '0) ? HW'(1) : height_q;
  end

  assign adv1       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv1;
  assign acc        = in_valid_i && !in_stall_o;
  assign pix        = acc && (kind_i == KIND_PIXEL);
  assign wdata      = {take_ch(blue_in_i), take_ch(green_in_i), take_ch(red_in_i)};

  always_comb begin
    b        = pending_q + PW'(pix);
    last_row = (out_row_q == eff_h - HW'(1));
    last_col = (out_col_q == eff_w - WW'(1));
    emit     = acc && (b != '0) && (last_row || (b > PW'(eff_w)))
               && (last_col || (b >= PW'(2)));

    wr_d = wr_q;
    if (pix) begin
      wr_d = (wr_q == AW'(RING - 1)) ? '0 : wr_q + 1'b1;
    end

    back_c  = AW'(b);
    back_up = AW'(b) + AW'(eff_w);
    back_dn = AW'(b) - AW'(eff_w);
    back_rt = AW'(b) - AW'(1);
    addr_c  = ring_addr(wr_d, back_c);
    addr_up = ring_addr(wr_d, back_up);
    addr_dn = ring_addr(wr_d, back_dn);
    addr_rt = ring_addr(wr_d, back_rt);

    sel_d.use_up    = (out_row_q != '0);
    sel_d.use_dn    = !last_row;
    sel_d.use_lf    = (out_col_q != '0);
    sel_d.use_rt    = !last_col;
    sel_d.fwd_c     = pix && (back_c == AW'(1));
    sel_d.fwd_dn    = pix && (back_dn == AW'(1));
    sel_d.fwd_rt    = pix && (back_rt == AW'(1));
    sel_d.frame_end = last_row && last_col;

    pending_d = b;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (emit) begin
      pending_d = b - PW'(1);
      out_col_d = last_col ? '0 : out_col_q + 1'b1;
      if (last_col) begin
        out_row_d = last_row ? '0 : out_row_q + 1'b1;
      end
    end

    width_d  = width_q;
    height_d = height_q;
    if (cfg_wr) begin
      if (paddr[APB_ADDR_BITS-1] == REG_IMAGE_WIDTH) begin
        width_d = pwdata[WIDTH_REG_BITS-1:0];
      end else begin
        height_d = pwdata[HEIGHT_REG_BITS-1:0];
      end
      pending_d = '0;
      out_col_d = '0;
      out_row_d = '0;
    end

    s1_valid_d  = emit || (s1_valid_q && !adv1);
    out_valid_d = adv1 || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      wr_q        <= '0;
      pending_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      wr_q        <= wr_d;
      pending_q   <= pending_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix) begin
      mem_a[wr_q] <= wdata;
    end
    if (emit) begin
      rd_c_q  <= mem_a[addr_c];
      rd_up_q <= mem_a[addr_up];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix) begin
      mem_b[wr_q] <= wdata;
    end
    if (emit) begin
      rd_dn_q <= mem_b[addr_dn];
      rd_rt_q <= mem_b[addr_rt];
    end
  end

  always_comb begin
    cpx = s1_sel_q.fwd_c ? s1_wdata_q : rd_c_q;
    upx = s1_sel_q.use_up ? rd_up_q : cpx;
    dnx = s1_sel_q.use_dn ? (s1_sel_q.fwd_dn ? s1_wdata_q : rd_dn_q) : cpx;
    rtx = s1_sel_q.use_rt ? (s1_sel_q.fwd_rt ? s1_wdata_q : rd_rt_q) : cpx;
    lfx = s1_sel_q.use_lf ? prev_c_q : cpx;
    for (int k = 0; k < 3; k++) begin
      res[k] = sharpen(cpx[k*CB +: CB], upx[k*CB +: CB], dnx[k*CB +: CB],
                       lfx[k*CB +: CB], rtx[k*CB +: CB]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_sel_q   <= sel_d;
      s1_wdata_q <= wdata;
    end
    if (adv1) begin
      prev_c_q    <= cpx;
      red_q       <= res[0];
      green_q     <= res[1];
      blue_q      <= res[2];
      frame_end_q <= s1_sel_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign frame_end_o = frame_end_q;

endmodule

>>> hw/rtl/scf_checker.sv
// Port-level checks of the sharpening filter, bound to its top level.
module scf_checker
  import scf_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [OUT_CH_BITS-1:0] red_out_o,
  input logic [OUT_CH_BITS-1:0] green_out_o,
  input logic [OUT_CH_BITS-1:0] blue_out_o,
  input logic                   frame_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_out_o) &&
    $stable(green_out_o) && $stable(blue_out_o) && $stable(frame_end_o))
    else $error("Stalled output transaction changed.");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("Output valid dropped without a completed transaction.");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled while the output side was free.");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("Output appeared without an input transaction two cycles before.");

endmodule

bind sharpen_cross_kernel_filter scf_checker u_scf_checker (.*);

>>> tb/sharpen_cross_kernel_filter_tb.sv
// Self-checking testbench for the cross-kernel sharpening filter with a built-in pixel predictor.
module sharpen_cross_kernel_filter_tb;
  import scf_pkg::*;

  localparam int unsigned MAX_COLS      = 1024;
  localparam int unsigned RING_DEPTH    = 2 * MAX_COLS + 2;
  localparam int unsigned RANDOM_PIXELS = 240;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STUCK_LIMIT   = 4000;
  localparam logic        KIND_DRAIN    = !KIND_PIXEL;

  typedef logic [23:0] rgb_t;
  typedef struct packed {
    logic [OUT_CH_BITS-1:0] red;
    logic [OUT_CH_BITS-1:0] green;
    logic [OUT_CH_BITS-1:0] blue;
    logic                   frame_end;
  } sharp_px_t;

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic                     kind_i      = KIND_PIXEL;
  logic [IN_CH_BITS-1:0]    red_in_i    = '0;
  logic [IN_CH_BITS-1:0]    green_in_i  = '0;
  logic [IN_CH_BITS-1:0]    blue_in_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [OUT_CH_BITS-1:0]   red_out_o;
  logic [OUT_CH_BITS-1:0]   green_out_o;
  logic [OUT_CH_BITS-1:0]   blue_out_o;
  logic                     frame_end_o;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr       = '0;
  logic [APB_DATA_BITS-1:0] pwdata      = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  sharpen_cross_kernel_filter #(
    .MAX_WIDTH   (MAX_COLS),
    .CHANNEL_BITS(8)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o),
    .frame_end_o(frame_end_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  rgb_t                       pix_hist [RING_DEPTH];
  int unsigned                hist_wp;
  int unsigned                emit_col;
  int unsigned                emit_row;
  int unsigned                backlog;
  logic [WIDTH_REG_BITS-1:0]  width_reg;
  logic [HEIGHT_REG_BITS-1:0] height_reg;
  sharp_px_t                  sharpened_q [$];

  int unsigned src_idle_pct  = 20;
  int unsigned sink_stall_pct = 45;
  int unsigned mismatch_count;
  int unsigned pixels_sent;
  int unsigned drains_sent;
  int unsigned results_checked;
  int unsigned frames_seen;
  int unsigned config_writes;
  int unsigned stuck_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  function automatic int unsigned active_width();
    int unsigned w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    return w;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic rgb_t hist_at(input int unsigned back);
    return pix_hist[(hist_wp + RING_DEPTH - (back % RING_DEPTH)) % RING_DEPTH];
  endfunction

  function automatic int chan(input rgb_t p, input int k);
    int v;
    v = p[8*k +: 8];
    return v;
  endfunction

  function automatic bit emit_ready();
    int unsigned w;
    int unsigned h;
    w = active_width();
    h = active_height();
    if (backlog == 0) return 1'b0;
    if (emit_row + 1 < h && backlog < w + 1) return 1'b0;
    if (emit_col + 1 < w && backlog < 2) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void restart_frame();
    emit_col = 0;
    emit_row = 0;
    backlog  = 0;
  endfunction

  task automatic predict_sharpen(input logic kind, input logic [7:0] r, g, b);
    int unsigned w;
    int unsigned h;
    int unsigned back;
    int          acc;
    int          k;
    rgb_t        ctr, up, dn, lf, rt;
    logic [7:0]  chan_out [0:2];
    sharp_px_t   res;
    w = active_width();
    h = active_height();
    if (kind == KIND_PIXEL) begin
      pix_hist[hist_wp] = {b, g, r};
      hist_wp = (hist_wp + 1) % RING_DEPTH;
      backlog++;
    end
    if (emit_ready()) begin
      back = backlog;
      ctr  = hist_at(back);
      up   = (emit_row > 0)     ? hist_at(back + w) : ctr;
      dn   = (emit_row + 1 < h) ? hist_at(back - w) : ctr;
      lf   = (emit_col > 0)     ? hist_at(back + 1) : ctr;
      rt   = (emit_col + 1 < w) ? hist_at(back - 1) : ctr;
      for (k = 0; k < 3; k++) begin
        acc = 5 * chan(ctr, k) - chan(up, k) - chan(dn, k) - chan(lf, k) - chan(rt, k);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        chan_out[k] = acc[7:0];
      end
      res.red       = chan_out[0];
      res.green     = chan_out[1];
      res.blue      = chan_out[2];
      res.frame_end = (emit_row + 1 == h) && (emit_col + 1 == w);
      sharpened_q.push_back(res);
      backlog--;
      emit_col++;
      if (emit_col >= w) begin
        emit_col = 0;
        emit_row++;
        if (emit_row >= h) emit_row = 0;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    sharp_px_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (sharpened_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual rgb %0d %0d %0d end %0b",
                 $time, red_out_o, green_out_o, blue_out_o, frame_end_o);
        mismatch_count++;
      end else begin
        want = sharpened_q.pop_front();
        if (want.frame_end) frames_seen++;
        check_field("red_out", want.red, red_out_o);
        check_field("green_out", want.green, green_out_o);
        check_field("blue_out", want.blue, blue_out_o);
        check_field("frame_end", want.frame_end, frame_end_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("sharpen_cross_kernel_filter_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] r, g, b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_sharpen(kind, r, g, b);
    if (kind == KIND_PIXEL) pixels_sent++;
    else drains_sent++;
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel();
    send_item(KIND_PIXEL, pick_channel(), pick_channel(), pick_channel());
  endtask

  task automatic send_drains(input int unsigned extra);
    while (emit_ready()) send_item(KIND_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    repeat (extra) send_item(KIND_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic src_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (sharpened_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle_before_write();
    src_quiet();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic access_reg(input logic reg_sel, input bit is_write, input logic [31:0] word);
    logic [31:0] held;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (is_write) begin
      if (reg_sel == REG_IMAGE_WIDTH) width_reg = word[WIDTH_REG_BITS-1:0];
      else height_reg = word[HEIGHT_REG_BITS-1:0];
      restart_frame();
      config_writes++;
    end else begin
      held = (reg_sel == REG_IMAGE_WIDTH) ? 32'(width_reg) : 32'(height_reg);
      if (prdata !== held) begin
        $display("%0t: prdata at %0d expected %0d actual %0d", $time, {reg_sel, 2'b00},
                 held, prdata);
        mismatch_count++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] word);
    access_reg(reg_sel, 1'b1, word);
    access_reg(reg_sel, 1'b0, '0);
  endtask

  task automatic test_register_reset_values();
    access_reg(REG_IMAGE_WIDTH, 1'b0, '0);
    access_reg(REG_IMAGE_HEIGHT, 1'b0, '0);
  endtask

  task automatic test_corner_pixels();
    rgb_t corner_px [0:8];
    int   i;
    corner_px = '{24'hFF0055, 24'h0080AA, 24'hFF0055, 24'h0080AA, 24'hFF7F00,
                  24'h00FFFF, 24'h800055, 24'h00FFAA, 24'h0100FF};
    write_reg(REG_IMAGE_WIDTH, 32'd3);
    write_reg(REG_IMAGE_HEIGHT, 32'd3);
    send_item(KIND_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    for (i = 0; i < 9; i++) begin
      send_item(KIND_PIXEL, corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);
    end
    send_drains(2);
  endtask

  task automatic test_restart_on_write();
    repeat (3) send_pixel();
    settle_before_write();
    write_reg(REG_IMAGE_WIDTH, 32'd2);
    repeat (6) send_pixel();
    send_drains(1);
    settle_before_write();
  endtask

  task automatic test_random_frames();
    int unsigned phase;
    int unsigned wr, hr;
    int unsigned frame_px, n, i;
    int unsigned random_px;
    logic [31:0] word;
    phase     = 0;
    random_px = 0;
    while (random_px < RANDOM_PIXELS) begin
      if (random_px >= 2 * RANDOM_PIXELS / 3) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end else if (random_px >= RANDOM_PIXELS / 3) begin
        src_idle_pct   = 45;
        sink_stall_pct = 20;
      end
      case (phase)
        0: begin wr = 0;    hr = 0;    end
        1: begin wr = 2047; hr = 1;    end
        2: begin wr = 1;    hr = 8191; end
        3: begin wr = 1024; hr = 4096; end
        4: begin wr = 1;    hr = 4096; end
        default: begin
          wr = ($urandom_range(5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          hr = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        end
      endcase
      settle_before_write();
      word = wr;
      if ($urandom_range(1)) word[31:WIDTH_REG_BITS] = $urandom;
      write_reg(REG_IMAGE_WIDTH, word);
      word = hr;
      if ($urandom_range(1)) word[31:HEIGHT_REG_BITS] = $urandom;
      write_reg(REG_IMAGE_HEIGHT, word);
      frame_px = active_width() * active_height();
      if (frame_px > 240) begin
        n = $urandom_range(10, 30);
      end else begin
        n = frame_px * $urandom_range(1, 3);
        if ($urandom_range(3) == 0) n -= $urandom_range(0, frame_px - 1);
      end
      if (n > RANDOM_PIXELS - random_px) n = RANDOM_PIXELS - random_px;
      for (i = 0; i < n; i++) begin
        if ((phase == 5 && i == n / 2) || $urandom_range(199) == 0) begin
          src_quiet();
          wait_drained();
        end
        if ($urandom_range(9) == 0) begin
          send_item(KIND_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        send_pixel();
        random_px++;
      end
      send_drains($urandom_range(2));
      phase++;
    end
  endtask

  task automatic test_full_width_rows();
    settle_before_write();
    write_reg(REG_IMAGE_WIDTH, 32'd1024);
    write_reg(REG_IMAGE_HEIGHT, 32'd3);
    repeat (MAX_COLS + 8) send_pixel();
    send_drains(2);
    settle_before_write();
    write_reg(REG_IMAGE_HEIGHT, 32'd1);
  endtask

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) pix_hist[i] = '0;
    hist_wp    = 0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    restart_frame();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_reset_values();
    test_corner_pixels();
    test_restart_on_write();
    test_random_frames();
    test_full_width_rows();
    src_quiet();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d pixels and %0d drain ticks across %0d register writes.",
             pixels_sent, drains_sent, config_writes);
    $display("Checked %0d sharpened pixels, %0d of them closing a frame.",
             results_checked, frames_seen);
    if (mismatch_count == 0) begin
      $display("sharpen_cross_kernel_filter_tb: PASS");
    end else begin
      $display("sharpen_cross_kernel_filter_tb: FAIL");
    end
    $finish;
  end

endmodule
